@@ rtl/core/obm_pkg.sv @@
`timescale 1ns / 1ps
package obm_pkg;

    localparam int MAX_ORDERS  = 16;
    localparam int IDXW        = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int MAX_RESULTS = 48;
    localparam int CNTW        = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] MD_ADD    = 3'd0;
    localparam logic [2:0] MD_MARKET = 3'd1;
    localparam logic [2:0] MD_CANCEL = 3'd2;
    localparam logic [2:0] MD_MODIFY = 3'd3;
    localparam logic [2:0] MD_BATCH  = 3'd4;
    localparam logic [2:0] MD_QUOTE  = 3'd5;

    localparam logic [3:0] EV_ADDED      = 4'd0;
    localparam logic [3:0] EV_TRADE      = 4'd1;
    localparam logic [3:0] EV_FILLED     = 4'd2;
    localparam logic [3:0] EV_PARTIAL    = 4'd3;
    localparam logic [3:0] EV_REJECTED   = 4'd4;
    localparam logic [3:0] EV_CANCELED   = 4'd5;
    localparam logic [3:0] EV_MODIFIED   = 4'd6;
    localparam logic [3:0] EV_UNKNOWN    = 4'd7;
    localparam logic [3:0] EV_NOTPENDING = 4'd8;
    localparam logic [3:0] EV_PARTCANCEL = 4'd9;
    localparam logic [3:0] EV_QUOTE      = 4'd10;
    localparam logic [3:0] EV_FULL       = 4'd11;
    localparam logic [3:0] EV_DUP        = 4'd12;

    localparam logic [1:0] WR_ADD  = 2'd0;
    localparam logic [1:0] WR_REM  = 2'd1;
    localparam logic [1:0] WR_KILL = 2'd2;

    typedef struct packed {
        logic            en;
        logic [1:0]      op;
        logic [IDXW-1:0] idx;
        logic [31:0]     id;
        logic            side;
        logic [31:0]     price;
        logic [31:0]     qty;
        logic [31:0]     arr;
    } t_wr;

    typedef struct packed {
        logic [31:0] key_id;
        logic [31:0] ctr;
        logic [31:0] blv;
        logic [31:0] alv;
    } t_scan;

    typedef struct packed {
        logic            hit;
        logic [IDXW-1:0] idx;
        logic [31:0]     id;
        logic [31:0]     price;
        logic [31:0]     rem;
        logic [31:0]     age;
    } t_best;

    typedef struct packed {
        logic            vld;
        logic            fid_hit;
        logic [IDXW-1:0] fid_idx;
        logic            fid_side;
        logic [31:0]     fid_price;
        logic [31:0]     fid_rem;
        logic            fid_touch;
        logic            free_hit;
        logic [IDXW-1:0] free_idx;
        t_best           bb;
        t_best           ba;
        logic [31:0]     bsum;
        logic [31:0]     asum;
    } t_tok;

    typedef struct packed {
        logic [3:0]  ev;
        logic [31:0] id;
        logic [31:0] other;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] ap;
        logic [31:0] aq;
    } t_res;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

@@ rtl/core/obm_cell.sv @@
`timescale 1ns / 1ps
module obm_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [obm_pkg::IDXW-1:0]  i_idx,
    input  obm_pkg::t_scan            i_scan,
    input  obm_pkg::t_wr              i_wr,
    input  obm_pkg::t_tok             i_tok,
    output obm_pkg::t_tok             o_tok
);
    import obm_pkg::*;

    logic        r_valid;
    logic [31:0] r_id;
    logic        r_side;
    logic [31:0] r_price;
    logic [31:0] r_rem;
    logic        r_touch;
    logic [31:0] r_arr;
    t_tok        r_tok;
    t_tok        n_tok;
    logic [31:0] w_age;
    logic        w_sel;

    assign w_sel = i_wr.en && (i_wr.idx == i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            case (i_wr.op)
                WR_ADD:  r_valid <= 1'b1;
                WR_REM:  r_valid <= (i_wr.qty != 32'd0);
                WR_KILL: r_valid <= 1'b0;
                default: r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            case (i_wr.op)
                WR_ADD: begin
                    r_id    <= i_wr.id;
                    r_side  <= i_wr.side;
                    r_price <= i_wr.price;
                    r_rem   <= i_wr.qty;
                    r_touch <= 1'b0;
                    r_arr   <= i_wr.arr;
                end
                WR_REM: begin
                    r_rem   <= i_wr.qty;
                    r_touch <= 1'b1;
                end
                default: begin
                    r_rem <= r_rem;
                end
            endcase
        end
    end

    assign w_age = i_scan.ctr - r_arr;

    always_comb begin
        n_tok = i_tok;
        if (r_valid && (r_id == i_scan.key_id) && !i_tok.fid_hit) begin
            n_tok.fid_hit   = 1'b1;
            n_tok.fid_idx   = i_idx;
            n_tok.fid_side  = r_side;
            n_tok.fid_price = r_price;
            n_tok.fid_rem   = r_rem;
            n_tok.fid_touch = r_touch;
        end
        if (!r_valid && !i_tok.free_hit) begin
            n_tok.free_hit = 1'b1;
            n_tok.free_idx = i_idx;
        end
        if (r_valid && !r_side) begin
            if (!i_tok.bb.hit || (r_price > i_tok.bb.price) ||
                ((r_price == i_tok.bb.price) && (w_age > i_tok.bb.age))) begin
                n_tok.bb = '{hit: 1'b1, idx: i_idx, id: r_id, price: r_price,
                             rem: r_rem, age: w_age};
            end
            if (r_price == i_scan.blv) n_tok.bsum = sat_add(i_tok.bsum, r_rem);
        end
        if (r_valid && r_side) begin
            if (!i_tok.ba.hit || (r_price < i_tok.ba.price) ||
                ((r_price == i_tok.ba.price) && (w_age > i_tok.ba.age))) begin
                n_tok.ba = '{hit: 1'b1, idx: i_idx, id: r_id, price: r_price,
                             rem: r_rem, age: w_age};
            end
            if (r_price == i_scan.alv) n_tok.asum = sat_add(i_tok.asum, r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) r_tok.vld <= 1'b0;
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/core/obm_ctrl.sv @@
`timescale 1ns / 1ps
module obm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic [2:0]      i_mode,
    input  logic [31:0]     i_order_id,
    input  logic            i_side,
    input  logic [31:0]     i_price,
    input  logic [31:0]     i_quantity,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output obm_pkg::t_res   o_res,
    output logic            o_last,
    output logic            o_go,
    output obm_pkg::t_scan  o_scan,
    output obm_pkg::t_wr    o_wr,
    input  obm_pkg::t_tok   i_tok
);
    import obm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WAIT  = 4'd1;
    localparam logic [3:0] S_ACT   = 4'd2;
    localparam logic [3:0] S_MOD2  = 4'd3;
    localparam logic [3:0] S_MOD3  = 4'd4;
    localparam logic [3:0] S_MPOST = 4'd5;
    localparam logic [3:0] S_MFIN  = 4'd6;
    localparam logic [3:0] S_BA    = 4'd7;
    localparam logic [3:0] S_BF    = 4'd8;
    localparam logic [3:0] S_AF    = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]      r_st, n_st;
    logic [2:0]      r_mode, n_mode;
    logic [31:0]     r_id, n_id;
    logic            r_side, n_side;
    logic [31:0]     r_price, n_price;
    logic [31:0]     r_qty, n_qty;
    logic [31:0]     r_rem, n_rem;
    logic [31:0]     r_m, n_m;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [31:0]     r_ctr, n_ctr;
    logic            r_q2, n_q2;
    logic            r_go, n_go;
    logic [31:0]     r_blv, n_blv;
    logic [31:0]     r_alv, n_alv;
    t_tok            r_tk, n_tk;
    logic            r_pv;
    t_res            r_pend;
    logic            r_ov;
    t_res            r_out;
    logic            r_olast;

    logic            w_can_emit;
    logic            w_out_free;
    logic            w_emit;
    logic            w_fin;
    t_res            w_e;
    t_best           w_ob;
    logic [31:0]     w_m_mkt;
    logic [31:0]     w_m_bat;
    logic [31:0]     w_ob_new;
    logic [31:0]     w_bb_new;
    logic [31:0]     w_ba_new;
    logic [CNTW:0]   w_cnt3;

    assign w_out_free = !r_ov || i_m_tready;
    assign w_can_emit = !r_pv || w_out_free;
    assign w_ob       = r_side ? r_tk.bb : r_tk.ba;
    assign w_m_mkt    = (r_rem < w_ob.rem) ? r_rem : w_ob.rem;
    assign w_m_bat    = (r_tk.bb.rem < r_tk.ba.rem) ? r_tk.bb.rem : r_tk.ba.rem;
    assign w_ob_new   = w_ob.rem - r_m;
    assign w_bb_new   = r_tk.bb.rem - r_m;
    assign w_ba_new   = r_tk.ba.rem - r_m;
    assign w_cnt3     = {1'b0, r_cnt} + (CNTW+1)'(3);

    always_comb begin
        n_st = r_st; n_mode = r_mode; n_id = r_id; n_side = r_side;
        n_price = r_price; n_qty = r_qty; n_rem = r_rem; n_m = r_m;
        n_cnt = r_cnt; n_ctr = r_ctr; n_q2 = r_q2; n_go = 1'b0;
        n_blv = r_blv; n_alv = r_alv; n_tk = r_tk;
        o_s_tready = 1'b0;
        w_emit = 1'b0;
        w_fin  = 1'b0;
        w_e    = '0;
        o_wr   = '0;
        case (r_st)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_mode = i_mode; n_id = i_order_id; n_side = i_side;
                    n_price = i_price; n_qty = i_quantity; n_rem = i_quantity;
                    n_cnt = '0; n_q2 = 1'b0;
                    case (i_mode)
                        MD_MARKET: begin
                            if (i_quantity == 32'd0) begin
                                n_st = S_MFIN;
                            end else begin
                                n_go = 1'b1; n_st = S_WAIT;
                            end
                        end
                        MD_ADD, MD_CANCEL, MD_MODIFY, MD_BATCH, MD_QUOTE: begin
                            n_go = 1'b1; n_st = S_WAIT;
                        end
                        default: n_st = S_IDLE;
                    endcase
                end
            end
            S_WAIT: begin
                if (i_tok.vld) begin
                    n_tk = i_tok;
                    n_st = S_ACT;
                end
            end
            S_ACT: begin
                case (r_mode)
                    MD_ADD: begin
                        if (w_can_emit) begin
                            w_emit = 1'b1;
                            w_e = '{ev: EV_ADDED, id: r_id, other: '0, side: r_side,
                                    price: r_price, qty: r_qty, ap: '0, aq: '0};
                            if (r_tk.fid_hit) begin
                                w_e.ev = EV_DUP;
                            end else if (!r_tk.free_hit) begin
                                w_e.ev = EV_FULL;
                            end else begin
                                o_wr = '{en: 1'b1, op: WR_ADD, idx: r_tk.free_idx, id: r_id,
                                         side: r_side, price: r_price, qty: r_qty,
                                         arr: r_ctr};
                                n_ctr = r_ctr + 32'd1;
                            end
                            n_st = S_FIN;
                        end
                    end
                    MD_CANCEL, MD_MODIFY: begin
                        if (w_can_emit) begin
                            w_emit = 1'b1;
                            n_st = S_FIN;
                            w_e = '{ev: EV_CANCELED, id: r_id, other: '0,
                                    side: r_tk.fid_side, price: r_tk.fid_price,
                                    qty: r_tk.fid_rem, ap: '0, aq: '0};
                            if (!r_tk.fid_hit) begin
                                w_e = '{ev: EV_UNKNOWN, id: r_id, default: '0};
                            end else if (r_tk.fid_touch) begin
                                w_e.ev = (r_mode == MD_CANCEL) ? EV_PARTCANCEL : EV_NOTPENDING;
                            end else if (r_mode == MD_CANCEL) begin
                                o_wr = '{en: 1'b1, op: WR_KILL, idx: r_tk.fid_idx,
                                         default: '0};
                            end else begin
                                // re-rest in place with a fresh arrival
                                o_wr = '{en: 1'b1, op: WR_ADD, idx: r_tk.fid_idx, id: r_id,
                                         side: r_tk.fid_side, price: r_price, qty: r_qty,
                                         arr: r_ctr};
                                n_ctr = r_ctr + 32'd1;
                                n_st = S_MOD2;
                            end
                        end
                    end
                    MD_MARKET: begin
                        if (!w_ob.hit) begin
                            n_st = S_MFIN;
                        end else if (w_can_emit) begin
                            w_emit = 1'b1;
                            n_m = w_m_mkt;
                            n_rem = r_rem - w_m_mkt;
                            o_wr = '{en: 1'b1, op: WR_REM, idx: w_ob.idx,
                                     qty: w_ob.rem - w_m_mkt, default: '0};
                            w_e = '{ev: EV_TRADE, id: r_side ? w_ob.id : r_id,
                                    other: r_side ? r_id : w_ob.id, side: r_side,
                                    price: w_ob.price, qty: w_m_mkt, ap: '0, aq: '0};
                            n_st = S_MPOST;
                        end
                    end
                    MD_BATCH: begin
                        if (!r_tk.bb.hit || !r_tk.ba.hit || (r_tk.bb.price < r_tk.ba.price) ||
                            (w_cnt3 > (CNTW+1)'(MAX_RESULTS))) begin
                            n_st = S_FIN;
                        end else if (w_can_emit) begin
                            w_emit = 1'b1;
                            n_m = w_m_bat;
                            o_wr = '{en: 1'b1, op: WR_REM, idx: r_tk.bb.idx,
                                     qty: r_tk.bb.rem - w_m_bat, default: '0};
                            w_e = '{ev: EV_TRADE, id: r_tk.bb.id, other: r_tk.ba.id,
                                    side: 1'b0, price: r_tk.ba.price, qty: w_m_bat,
                                    ap: '0, aq: '0};
                            n_st = S_BA;
                        end
                    end
                    MD_QUOTE: begin
                        if (!r_q2) begin
                            // second pass sums the two best levels
                            n_blv = r_tk.bb.price;
                            n_alv = r_tk.ba.price;
                            n_q2 = 1'b1;
                            n_go = 1'b1;
                            n_st = S_WAIT;
                        end else if (w_can_emit) begin
                            w_emit = 1'b1;
                            w_e = '{ev: EV_QUOTE, id: '0, other: '0, side: 1'b0,
                                    price: r_tk.bb.hit ? r_tk.bb.price : 32'd0,
                                    qty:   r_tk.bb.hit ? r_tk.bsum : 32'd0,
                                    ap:    r_tk.ba.hit ? r_tk.ba.price : 32'd0,
                                    aq:    r_tk.ba.hit ? r_tk.asum : 32'd0};
                            n_st = S_FIN;
                        end
                    end
                    default: n_st = S_FIN;
                endcase
            end
            S_MOD2, S_MOD3: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    w_e = '{ev: (r_st == S_MOD2) ? EV_ADDED : EV_MODIFIED, id: r_id,
                            other: '0, side: r_tk.fid_side, price: r_price, qty: r_qty,
                            ap: '0, aq: '0};
                    n_st = (r_st == S_MOD2) ? S_MOD3 : S_FIN;
                end
            end
            S_MPOST: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    w_e = '{ev: (w_ob_new == 32'd0) ? EV_FILLED : EV_PARTIAL, id: w_ob.id,
                            other: '0, side: !r_side, price: w_ob.price, qty: w_ob_new,
                            ap: '0, aq: '0};
                    if (r_rem == 32'd0) begin
                        n_st = S_MFIN;
                    end else begin
                        n_go = 1'b1; n_st = S_WAIT;
                    end
                end
            end
            S_MFIN: begin
                if (w_can_emit) begin
                    w_emit = 1'b1;
                    w_e = '{ev: (r_rem != 32'd0) ? EV_REJECTED : EV_FILLED, id: r_id,
                            other: '0, side: r_side, price: '0, qty: r_rem,
                            ap: '0, aq: '0};
                    n_st = S_FIN;
                end
            end
            S_BA: begin
                o_wr = '{en: 1'b1, op: WR_REM, idx: r_tk.ba.idx, qty: w_ba_new, default: '0};
                n_st = S_BF;
            end
            S_BF: begin
                if (w_bb_new != 32'd0) begin
                    n_st = S_AF;
                end else if (w_can_emit) begin
                    w_emit = 1'b1;
                    w_e = '{ev: EV_FILLED, id: r_tk.bb.id, other: '0, side: 1'b0,
                            price: r_tk.bb.price, qty: '0, ap: '0, aq: '0};
                    n_st = S_AF;
                end
            end
            S_AF: begin
                if (w_ba_new != 32'd0) begin
                    n_go = 1'b1; n_st = S_WAIT;
                end else if (w_can_emit) begin
                    w_emit = 1'b1;
                    w_e = '{ev: EV_FILLED, id: r_tk.ba.id, other: '0, side: 1'b1,
                            price: r_tk.ba.price, qty: '0, ap: '0, aq: '0};
                    n_go = 1'b1; n_st = S_WAIT;
                end
            end
            S_FIN: begin
                // release the held word with last set
                if (!r_pv) begin
                    n_st = S_IDLE;
                end else if (w_out_free) begin
                    w_fin = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
        if (w_emit) n_cnt = r_cnt + CNTW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_ctr <= '0;
            r_go  <= 1'b0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_ctr <= n_ctr;
            r_go  <= n_go;
            if (w_emit) begin
                r_pv <= 1'b1;
                if (r_pv) r_ov <= 1'b1;
                else if (r_ov && i_m_tready) r_ov <= 1'b0;
            end else if (w_fin) begin
                r_pv <= 1'b0;
                r_ov <= 1'b1;
            end else if (r_ov && i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode; r_id <= n_id; r_side <= n_side; r_price <= n_price;
        r_qty <= n_qty; r_rem <= n_rem; r_m <= n_m; r_cnt <= n_cnt; r_q2 <= n_q2;
        r_blv <= n_blv; r_alv <= n_alv; r_tk <= n_tk;
        if (w_emit) begin
            r_pend <= w_e;
            if (r_pv) begin
                r_out   <= r_pend;
                r_olast <= 1'b0;
            end
        end else if (w_fin) begin
            r_out   <= r_pend;
            r_olast <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_res      = r_out;
    assign o_last     = r_olast;
    assign o_go       = r_go;
    assign o_scan     = '{key_id: r_id, ctr: r_ctr, blv: r_blv, alv: r_alv};

endmodule

@@ rtl/core/limit_order_book_matcher.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake            Payload
// s (cmd)   in   i_s_tvalid/o_s_tready tuser: mode; tdata: id, side, price, quantity
// m (event) out  o_m_tvalid/i_m_tready tuser: event code; tdata: event fields; tlast
//
// Every table scan sends one token down the row of MAX_ORDERS slot cells, one cell per
// cycle. Add, cancel and modify take one scan, quote two, a market or batch command one
// scan per fill step.
// One command at a time: the command port stays low until its last event is queued.
// Reset (synchronous, active low) empties the table and zeros the arrival counter.
// A stalled event port holds the word and stops the sequencer; no event is dropped.
module limit_order_book_matcher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [2:0]   i_s_tuser,   // [2:0] mode
    input  logic [103:0] i_s_tdata,   // order_id, side, price, quantity, zero fill
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [3:0]   o_m_tuser,   // [3:0] event_res
    output logic [199:0] o_m_tdata,   // event_order_id, other_order_id, event_side,
                                      // event_price, event_quantity, ask_price,
                                      // ask_quantity, zero fill
    output logic         o_m_tlast
);
    import obm_pkg::*;

    t_tok  w_tok [0:MAX_ORDERS];
    t_scan w_scan;
    t_wr   w_wr;
    t_res  w_res;
    logic  w_go;

    // empty token enters the head of the row on a scan start
    always_comb begin
        w_tok[0]     = '0;
        w_tok[0].vld = w_go;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ORDERS; g++) begin : g_cell
            obm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (IDXW'(g)),
                .i_scan  (w_scan),
                .i_wr    (w_wr),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    obm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_mode     (i_s_tuser),
        .i_order_id (i_s_tdata[31:0]),
        .i_side     (i_s_tdata[32]),
        .i_price    (i_s_tdata[64:33]),
        .i_quantity (i_s_tdata[96:65]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (w_res),
        .o_last     (o_m_tlast),
        .o_go       (w_go),
        .o_scan     (w_scan),
        .o_wr       (w_wr),
        .i_tok      (w_tok[MAX_ORDERS])
    );

    assign o_m_tuser = w_res.ev;
    assign o_m_tdata = {7'd0, w_res.aq, w_res.ap, w_res.qty, w_res.price, w_res.side,
                        w_res.other, w_res.id};

endmodule

@@ rtl/core/obm_checker.sv @@
`timescale 1ns / 1ps
module obm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [2:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [3:0] o_m_tuser,
    input logic       o_m_tlast
);
    import obm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("event word dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser != 3'd6) && (i_s_tuser != 3'd7)
        |=> !o_s_tready)
        else $error("command port open while a command is in work");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("event valid after reset");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && ((o_m_tuser == EV_QUOTE) || (o_m_tuser == EV_DUP) ||
                       (o_m_tuser == EV_FULL) || (o_m_tuser == EV_UNKNOWN))
        |-> o_m_tlast)
        else $error("single-event result without last");

endmodule

bind limit_order_book_matcher obm_checker u_obm_checker (.*);

@@ tb/tb_limit_order_book_matcher.sv @@
`timescale 1ns / 1ps
module tb_limit_order_book_matcher;
    import obm_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] id;
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
        bit          drain;   // hold this command until the book has answered everything
    } t_cmd;

    typedef struct {
        t_res r;
        bit   last;
    } t_event;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [2:0]   i_s_tuser = '0;
    logic [103:0] i_s_tdata = '0;   // order_id, side, price, quantity, zero fill
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [3:0]   o_m_tuser;        // event_res
    logic [199:0] o_m_tdata;        // event_order_id, other_order_id, event_side,
                                    // event_price, event_quantity, ask_price, ask_quantity
    logic         o_m_tlast;

    limit_order_book_matcher u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow book
    bit          bk_valid [MAX_ORDERS];
    bit [31:0]   bk_id    [MAX_ORDERS];
    bit          bk_side  [MAX_ORDERS];
    bit [31:0]   bk_price [MAX_ORDERS];
    bit [31:0]   bk_rem   [MAX_ORDERS];
    bit          bk_touch [MAX_ORDERS];
    bit [31:0]   bk_arr   [MAX_ORDERS];
    bit [31:0]   bk_ctr;

    t_cmd   cmd_queue[$];
    t_event step_events[$];
    t_event pending_events[$];
    int     errors;
    int     accepted;

    task automatic report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic void emit(logic [3:0] ev, logic [31:0] id, logic [31:0] other,
                                 logic sd, logic [31:0] pr, logic [31:0] qt,
                                 logic [31:0] ap, logic [31:0] aq);
        t_event e;
        if (step_events.size() >= MAX_RESULTS) return;
        e.r = '{ev: ev, id: id, other: other, side: sd, price: pr, qty: qt, ap: ap, aq: aq};
        e.last = 1'b0;
        step_events.insert(step_events.size(), e);
    endfunction

    function automatic void emit_order(logic [3:0] ev, int s);
        emit(ev, bk_id[s], 0, bk_side[s], bk_price[s], bk_rem[s], 0, 0);
    endfunction

    function automatic int find_order(logic [31:0] id);
        for (int i = 0; i < MAX_ORDERS; i++)
            if (bk_valid[i] && bk_id[i] == id) return i;
        return -1;
    endfunction

    // Best price first, oldest arrival within a price
    function automatic int best_order(bit sd);
        int b;
        bit [31:0] ai, ab;
        b = -1;
        for (int i = 0; i < MAX_ORDERS; i++) begin
            if (!bk_valid[i] || bk_side[i] != sd) continue;
            if (b < 0) begin
                b = i;
                continue;
            end
            ai = bk_ctr - bk_arr[i];
            ab = bk_ctr - bk_arr[b];
            if (bk_price[i] != bk_price[b]) begin
                if (sd == 1'b0 ? bk_price[i] > bk_price[b] : bk_price[i] < bk_price[b])
                    b = i;
            end else if (ai > ab) begin
                b = i;
            end
        end
        return b;
    endfunction

    function automatic bit [31:0] level_sum(bit sd, bit [31:0] pr);
        bit [32:0] t;
        t = 0;
        for (int i = 0; i < MAX_ORDERS; i++)
            if (bk_valid[i] && bk_side[i] == sd && bk_price[i] == pr) begin
                t = t + bk_rem[i];
                if (t[32]) t = 33'h0_FFFF_FFFF;
            end
        return t[31:0];
    endfunction

    function automatic void rest_order(int s, bit [31:0] id, bit sd, bit [31:0] pr,
                                       bit [31:0] qt);
        bk_valid[s] = 1'b1; bk_id[s] = id; bk_side[s] = sd;
        bk_price[s] = pr; bk_rem[s] = qt; bk_touch[s] = 1'b0;
        bk_arr[s] = bk_ctr;
        bk_ctr = bk_ctr + 32'd1;
    endfunction

    function automatic void book_step(t_cmd c);
        int s, p, b, a;
        bit [31:0] rem, m, bp, bq, ap, aq;
        step_events.delete();
        case (c.mode)
            MD_ADD: begin
                if (find_order(c.id) >= 0) begin
                    emit(EV_DUP, c.id, 0, c.side, c.price, c.qty, 0, 0);
                end else begin
                    s = -1;
                    for (int i = MAX_ORDERS - 1; i >= 0; i--) if (!bk_valid[i]) s = i;
                    if (s < 0) begin
                        emit(EV_FULL, c.id, 0, c.side, c.price, c.qty, 0, 0);
                    end else begin
                        rest_order(s, c.id, c.side, c.price, c.qty);
                        emit_order(EV_ADDED, s);
                    end
                end
            end
            MD_MARKET: begin
                rem = c.qty;
                while (rem > 0) begin
                    p = best_order(!c.side);
                    if (p < 0) break;
                    m = rem < bk_rem[p] ? rem : bk_rem[p];
                    rem -= m;
                    bk_rem[p] -= m;
                    bk_touch[p] = 1'b1;
                    if (c.side == 1'b0) emit(EV_TRADE, c.id, bk_id[p], c.side, bk_price[p], m, 0, 0);
                    else                emit(EV_TRADE, bk_id[p], c.id, c.side, bk_price[p], m, 0, 0);
                    if (bk_rem[p] == 0) begin
                        bk_valid[p] = 1'b0;
                        emit_order(EV_FILLED, p);
                    end else begin
                        emit_order(EV_PARTIAL, p);
                    end
                end
                emit(rem > 0 ? EV_REJECTED : EV_FILLED, c.id, 0, c.side, 0, rem, 0, 0);
            end
            MD_CANCEL, MD_MODIFY: begin
                s = find_order(c.id);
                if (s < 0) begin
                    emit(EV_UNKNOWN, c.id, 0, 1'b0, 0, 0, 0, 0);
                end else if (bk_touch[s]) begin
                    emit_order(c.mode == MD_CANCEL ? EV_PARTCANCEL : EV_NOTPENDING, s);
                end else begin
                    bk_valid[s] = 1'b0;
                    emit_order(EV_CANCELED, s);
                    if (c.mode == MD_MODIFY) begin
                        rest_order(s, c.id, bk_side[s], c.price, c.qty);
                        emit_order(EV_ADDED, s);
                        emit_order(EV_MODIFIED, s);
                    end
                end
            end
            MD_BATCH: begin
                forever begin
                    b = best_order(1'b0);
                    a = best_order(1'b1);
                    if (b < 0 || a < 0) break;
                    if (bk_price[b] < bk_price[a]) break;
                    if (step_events.size() + 3 > MAX_RESULTS) break;
                    m = bk_rem[b] < bk_rem[a] ? bk_rem[b] : bk_rem[a];
                    bk_rem[b] -= m; bk_rem[a] -= m;
                    bk_touch[b] = 1'b1; bk_touch[a] = 1'b1;
                    emit(EV_TRADE, bk_id[b], bk_id[a], 1'b0, bk_price[a], m, 0, 0);
                    if (bk_rem[b] == 0) begin bk_valid[b] = 1'b0; emit_order(EV_FILLED, b); end
                    if (bk_rem[a] == 0) begin bk_valid[a] = 1'b0; emit_order(EV_FILLED, a); end
                end
            end
            MD_QUOTE: begin
                b = best_order(1'b0);
                a = best_order(1'b1);
                bp = 0; bq = 0; ap = 0; aq = 0;
                if (b >= 0) begin bp = bk_price[b]; bq = level_sum(1'b0, bp); end
                if (a >= 0) begin ap = bk_price[a]; aq = level_sum(1'b1, ap); end
                emit(EV_QUOTE, 0, 0, 1'b0, bp, bq, ap, aq);
            end
            default: ;
        endcase
        if (step_events.size() > 0) step_events[$].last = 1'b1;
        foreach (step_events[i]) pending_events.insert(pending_events.size(), step_events[i]);
    endfunction

    task automatic push_cmd(logic [2:0] mode, logic [31:0] id, logic sd, logic [31:0] pr,
                            logic [31:0] qt, bit drain = 0);
        t_cmd c;
        c = '{mode: mode, id: id, side: sd, price: pr, qty: qt, drain: drain};
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(10, 40);
    endfunction

    // Cycle counter and timeout
    int cycles;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Command driver
    t_cmd cur_cmd;
    int   s_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                book_step(cur_cmd);
                accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (cmd_queue.size() > 0 &&
                             !(cmd_queue[0].drain && pending_events.size() > 0)) begin
                    cur_cmd = cmd_queue[0];
                    cmd_queue.delete(0);
                    i_s_tuser <= cur_cmd.mode;
                    i_s_tdata <= {7'd0, cur_cmd.qty, cur_cmd.price, cur_cmd.side, cur_cmd.id};
                    i_s_tvalid <= 1'b1;
                    // no idling through the middle third of the command stream
                    s_gap = (accepted > 150 && accepted < 300) ? 0 : pick_gap();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Event monitor and receiver stalls
    int  m_gap;
    int  m_hold;
    bit  held_once;
    t_res   got;
    t_event want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{ev: o_m_tuser, id: o_m_tdata[31:0], other: o_m_tdata[63:32],
                        side: o_m_tdata[64], price: o_m_tdata[96:65],
                        qty: o_m_tdata[128:97], ap: o_m_tdata[160:129],
                        aq: o_m_tdata[192:161]};
                if (pending_events.size() == 0) begin
                    report($sformatf("unexpected event %0d id %0h", got.ev, got.id));
                end else begin
                    want = pending_events[0];
                    pending_events.delete(0);
                    if (got.ev !== want.r.ev)
                        report($sformatf("event code %0d, want %0d", got.ev, want.r.ev));
                    if (got.id !== want.r.id)
                        report($sformatf("order id %0h, want %0h", got.id, want.r.id));
                    if (got.other !== want.r.other)
                        report($sformatf("other id %0h, want %0h", got.other, want.r.other));
                    if (got.side !== want.r.side)
                        report($sformatf("side %0b, want %0b", got.side, want.r.side));
                    if (got.price !== want.r.price)
                        report($sformatf("price %0h, want %0h", got.price, want.r.price));
                    if (got.qty !== want.r.qty)
                        report($sformatf("quantity %0h, want %0h", got.qty, want.r.qty));
                    if (got.ap !== want.r.ap)
                        report($sformatf("ask price %0h, want %0h", got.ap, want.r.ap));
                    if (got.aq !== want.r.aq)
                        report($sformatf("ask quantity %0h, want %0h", got.aq, want.r.aq));
                    if (o_m_tlast !== want.last)
                        report($sformatf("last %0b, want %0b", o_m_tlast, want.last));
                end
            end
            if (!held_once && accepted >= 120) begin
                // long back-pressure so the book backs up into the command port
                held_once = 1'b1;
                m_hold = 3000;
            end
            if (m_hold > 0) begin
                m_hold--;
                i_m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!(accepted > 300 && accepted < 380) && $urandom_range(0, 3) == 0)
                    m_gap = pick_gap();
            end
        end
    end

    function automatic logic [31:0] rand_id();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return $urandom_range(0, 23);
    endfunction

    function automatic logic [31:0] rand_price();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return 1000 + $urandom_range(0, 12) - 6;
        endcase
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 19))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    initial begin
        int r;
        logic [2:0] md;
        // directed part
        push_cmd(MD_QUOTE, 0, 1'b0, 0, 0);
        push_cmd(MD_ADD, 0, 1'b0, 100, 0);                       // zero quantity rests
        push_cmd(MD_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(MD_ADD, 0, 1'b1, 5, 5);                         // duplicate id
        push_cmd(MD_ADD, 1, 1'b1, 90, 5);
        push_cmd(MD_BATCH, 0, 1'b0, 0, 0);                       // zero-quantity trade
        push_cmd(MD_BATCH, 0, 1'b0, 0, 0);                       // nothing crosses
        push_cmd(MD_ADD, 2, 1'b0, 80, 32'hFFFF_FFFF);
        push_cmd(MD_ADD, 3, 1'b0, 80, 10);
        push_cmd(MD_QUOTE, 0, 1'b0, 0, 0);                       // saturated bid total
        push_cmd(MD_MARKET, 50, 1'b1, 0, 3);
        push_cmd(MD_CANCEL, 2, 1'b1, 0, 0);                      // touched: partcancel
        push_cmd(MD_MODIFY, 2, 1'b0, 1, 1);                      // touched: notpending
        push_cmd(MD_MODIFY, 3, 1'b1, 95, 7);
        push_cmd(MD_CANCEL, 999, 1'b0, 0, 0);
        push_cmd(MD_MODIFY, 998, 1'b0, 0, 0);
        push_cmd(MD_MARKET, 51, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(MD_MARKET, 52, 1'b0, 0, 4);                     // fills from the remaining ask
        push_cmd(3'd6, 7, 1'b1, 7, 7);
        push_cmd(3'd7, 7, 1'b1, 7, 7);
        for (int i = 0; i < MAX_ORDERS; i++)
            push_cmd(MD_ADD, 100 + i, 1'(i % 2), 500 + (i % 3), 4, i == 0);
        push_cmd(MD_ADD, 200, 1'b0, 1, 1);                       // table full
        push_cmd(MD_BATCH, 0, 1'b0, 0, 0);
        push_cmd(MD_QUOTE, 0, 1'b0, 0, 0);
        // random part
        for (int n = 0; n < 410; n++) begin
            r = $urandom_range(0, 99);
            if      (r < 45) md = MD_ADD;
            else if (r < 57) md = MD_MARKET;
            else if (r < 69) md = MD_CANCEL;
            else if (r < 79) md = MD_MODIFY;
            else if (r < 89) md = MD_BATCH;
            else if (r < 97) md = MD_QUOTE;
            else             md = 3'($urandom_range(6, 7));
            push_cmd(md, rand_id(), 1'($urandom_range(0, 1)), rand_price(), rand_qty(),
                     n % 60 == 59);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (cmd_queue.size() > 0 || i_s_tvalid || pending_events.size() > 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ limit_order_book_matcher.f @@
rtl/core/obm_pkg.sv
rtl/core/obm_cell.sv
rtl/core/obm_ctrl.sv
rtl/core/limit_order_book_matcher.sv
rtl/core/obm_checker.sv
tb/tb_limit_order_book_matcher.sv
